@@ rtl/ipd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR proximity detector package
// Shared types and constants for the modulated IR proximity detector.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int SampleW = 10;
  localparam int AccW    = 16;
  localparam int CountW  = 6;
  localparam int HoldW   = 16;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS = 8'd1;

  localparam logic [SampleW-1:0] THRESHOLD_RESET  = 10'd2;
  localparam logic [HoldW-1:0]   HOLD_TICKS_RESET = 16'd100;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_TICK   = 1'b1;

  typedef enum logic [1:0] {
    PH_LIT  = 2'd0,
    PH_DARK = 2'd1,
    PH_HOLD = 2'd2
  } ipd_phase_t;

  typedef struct packed {
    logic [SampleW-1:0] threshold;
    logic [HoldW-1:0]   hold_ticks;
  } ipd_cfg_t;

  typedef struct packed {
    logic               led_on;
    logic               proximity;
    logic               decision;
    logic [SampleW-1:0] on_average;
    logic [SampleW-1:0] off_average;
  } ipd_result_t;

endpackage

@@ rtl/ipd_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR proximity detector configuration registers
// Holds the comparison threshold and the hold time written over the
// configuration channel.
// ----------------------------------------------------------------------------
module ipd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ipd_pkg::CfgDataW-1:0]    cfg_data,
  output ipd_pkg::ipd_cfg_t               cfg
);
  import ipd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= THRESHOLD_RESET;
      cfg.hold_ticks <= HOLD_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD:  cfg.threshold  <= cfg_data[SampleW-1:0];
        REG_HOLD_TICKS: cfg.hold_ticks <= cfg_data[HoldW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ipd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR proximity detector core
// Phase sequencer, sample averaging and lit/dark comparison. All state is
// updated in the cycle an input item is transferred.
// ----------------------------------------------------------------------------
module ipd_core #(
  parameter int AVG_LOG2 = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          action,
  input  logic [ipd_pkg::SampleW-1:0]   sample,
  input  ipd_pkg::ipd_cfg_t             cfg,
  output ipd_pkg::ipd_result_t          result_next
);
  import ipd_pkg::*;

  localparam logic [CountW-1:0] CountLast = CountW'((1 << AVG_LOG2) - 1);

  ipd_phase_t         phase, phase_next;
  logic [AccW-1:0]    accumulator, accumulator_next;
  logic [CountW-1:0]  sample_count, sample_count_next;
  logic [SampleW-1:0] lit_level, lit_level_next;
  logic [SampleW-1:0] dark_level, dark_level_next;
  logic [HoldW-1:0]   hold_left, hold_left_next;
  logic               signal_out, signal_out_next;
  logic               decided;
  logic [AccW-1:0]    acc_sum;
  logic               group_done;
  logic [SampleW-1:0] avg;
  logic               detect;

  assign acc_sum    = accumulator + AccW'(sample);
  assign group_done = (sample_count >= CountLast);
  assign avg        = SampleW'(acc_sum >> AVG_LOG2);
  assign detect     = ({1'b0, lit_level} + {1'b0, cfg.threshold}) < {1'b0, avg};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LIT;
      accumulator  <= '0;
      sample_count <= '0;
      lit_level    <= '0;
      dark_level   <= '0;
      hold_left    <= '0;
      signal_out   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      accumulator  <= accumulator_next;
      sample_count <= sample_count_next;
      lit_level    <= lit_level_next;
      dark_level   <= dark_level_next;
      hold_left    <= hold_left_next;
      signal_out   <= signal_out_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    accumulator_next  = accumulator;
    sample_count_next = sample_count;
    lit_level_next    = lit_level;
    dark_level_next   = dark_level;
    hold_left_next    = hold_left;
    signal_out_next   = signal_out;
    decided           = 1'b0;

    case (phase)
      PH_HOLD: begin
        if (action == ACTION_TICK) begin
          if (hold_left <= HoldW'(1)) begin
            hold_left_next = '0;
            phase_next     = PH_LIT;
          end else begin
            hold_left_next = hold_left - HoldW'(1);
          end
        end
      end
      PH_DARK: begin
        if (action == ACTION_SAMPLE) begin
          if (group_done) begin
            accumulator_next  = '0;
            sample_count_next = '0;
            dark_level_next   = avg;
            decided           = 1'b1;
            if (detect) begin
              signal_out_next = 1'b1;
              hold_left_next  = cfg.hold_ticks;
              phase_next      = (cfg.hold_ticks == '0) ? PH_LIT : PH_HOLD;
            end else begin
              signal_out_next = 1'b0;
              phase_next      = PH_LIT;
            end
          end else begin
            accumulator_next  = acc_sum;
            sample_count_next = sample_count + CountW'(1);
          end
        end
      end
      default: begin
        if (action == ACTION_SAMPLE) begin
          if (group_done) begin
            accumulator_next  = '0;
            sample_count_next = '0;
            lit_level_next    = avg;
            phase_next        = PH_DARK;
          end else begin
            accumulator_next  = acc_sum;
            sample_count_next = sample_count + CountW'(1);
          end
        end
      end
    endcase

    result_next.led_on      = (phase_next == PH_LIT);
    result_next.proximity   = signal_out_next;
    result_next.decision    = decided;
    result_next.on_average  = lit_level_next;
    result_next.off_average = dark_level_next;
  end

  a_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HOLD) |-> (hold_left != '0))
    else $error("hold phase entered with no ticks left");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CountLast)
    else $error("sample count ran past the group size");

  a_decision_leaves_dark: assert property (@(posedge clk) disable iff (rst)
    (accept && decided) |=> (phase != PH_DARK) && (sample_count == '0))
    else $error("comparison did not end the dark phase");

  a_hold_ignores_samples: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_HOLD && action == ACTION_SAMPLE) |=>
      (phase == PH_HOLD) && $stable(hold_left))
    else $error("sample changed the hold state");

endmodule

@@ rtl/ipd_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR proximity detector result register
// Holds one result until the downstream side takes it. A new item may be
// transferred in the same cycle the held result leaves.
// ----------------------------------------------------------------------------
module ipd_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ipd_pkg::ipd_result_t  result_next,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ipd_pkg::ipd_result_t  result
);
  import ipd_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/ir_proximity_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR proximity detector
// Averages lit and dark phototransistor samples, compares them and drives
// the IR LED and the proximity output.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    action, sample
//   out      out_valid / out_ready  led_on, proximity, decision,
//                                   on_average, off_average
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every input item produces exactly one result, registered in the cycle after its transfer.
// One item per cycle is sustained while out_ready is high; the single result register sets the rate.
// in_ready is low only while a result is held and out_ready is low.
// The configuration channel is always ready.
// Synchronous reset returns the block to the lit phase with cleared levels.
// ----------------------------------------------------------------------------
module ir_proximity_detector #(
  parameter int AVG_LOG2 = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [ipd_pkg::SampleW-1:0]   sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          led_on,
  output logic                          proximity,
  output logic                          decision,
  output logic [ipd_pkg::SampleW-1:0]   on_average,
  output logic [ipd_pkg::SampleW-1:0]   off_average,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ipd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ipd_pkg::CfgDataW-1:0]  cfg_data
);
  import ipd_pkg::*;

  ipd_cfg_t    cfg;
  ipd_result_t result_next;
  ipd_result_t result;
  logic        accept;

  assign accept = in_valid && in_ready;

  ipd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipd_core #(
    .AVG_LOG2 (AVG_LOG2)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .sample      (sample),
    .cfg         (cfg),
    .result_next (result_next)
  );

  ipd_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .result_next (result_next),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  assign led_on      = result.led_on;
  assign proximity   = result.proximity;
  assign decision    = result.decision;
  assign on_average  = result.on_average;
  assign off_average = result.off_average;

endmodule
